>>> sv/ipv6_prefix_membership_table_top_assert.svh
// Assertion macros for the IPv6 prefix membership table.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef IPV6_PREFIX_MEMBERSHIP_TABLE_TOP_ASSERT_SVH
`define IPV6_PREFIX_MEMBERSHIP_TABLE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Plain property, checked at every rising edge outside reset.
`define IPFX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define IPFX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define IPFX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IPFX_ASSERT(lbl, clk, rst_n, prop, msg)
`define IPFX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define IPFX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/ipfx_pkg.sv
// Shared types, constants and the prefix mask function for the prefix table.
// No dependencies; used by ipfx_match, the top level and the bench.
package ipfx_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ISSUE_W       = IDX_W + 1;
  localparam int ADDR_W        = 128;
  localparam int HALF_W        = 64;
  localparam int LEN_W         = 8;
  localparam int CNT_W         = 7;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COVERED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADLEN  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] net;
    logic [LEN_W-1:0]  len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic covers;     // key lies inside the stored prefix
    logic contained;  // stored network lies inside the key prefix
  } match_t;

  // Network order: the first bit is the MSB (bit ADDR_W-1); a /n mask sets the top n bits.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

>>> sv/ipfx_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module ipfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

>>> sv/ipfx_match.sv
// Compares one stored prefix against the command key in both directions.
// Depends on ipfx_pkg.
module ipfx_match (
  input  ipfx_pkg::entry_t                 entry,
  input  logic                             entry_valid,
  input  logic [ipfx_pkg::ADDR_W-1:0]      key,
  input  logic [ipfx_pkg::ADDR_W-1:0]      key_mask,
  output ipfx_pkg::match_t                 result
);
  logic [ipfx_pkg::ADDR_W-1:0] entry_mask;

  assign entry_mask = ipfx_pkg::prefix_mask(entry.len);

  always_comb begin
    result.covers    = entry_valid && ((key & entry_mask) == entry.net);
    result.contained = entry_valid && ((entry.net & key_mask) == key);
  end
endmodule

>>> sv/ipv6_prefix_membership_table_top.sv
// Top level of the IPv6 prefix membership table: command sequencer, valid bits,
// entry scan and result register. Depends on ipfx_pkg, ipfx_ram, ipfx_match
// and the assertion macro header.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in_     | input     | in_valid/in_stall  | command, addr_high, addr_low, prefix_len
//  out_    | output    | out_valid/out_stall| hit, status, entry_count
//
// A lookup or a well-formed insert scans the whole table through the entry RAM:
// the accepting step, a read of every entry over the single RAM read port, the
// registered read and the finish step. Clear, a bad length or an unused command
// skip the scan and go from the accepting step straight to the finish step.
// Synchronous active-low reset empties the table at once (valid bits in flops).
// The next item is taken while a result waits; a stalled result holds the
// finish step until the output register frees up.
`include "ipv6_prefix_membership_table_top_assert.svh"

module ipv6_prefix_membership_table_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ipfx_pkg::CMD_W-1:0]         in_command,
  input  logic [ipfx_pkg::HALF_W-1:0]        in_addr_high,
  input  logic [ipfx_pkg::HALF_W-1:0]        in_addr_low,
  input  logic [ipfx_pkg::LEN_W-1:0]         in_prefix_len,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_hit,
  output logic [ipfx_pkg::STATUS_W-1:0]      out_status,
  output logic [ipfx_pkg::CNT_W-1:0]         out_entry_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r;

  // Table state
  logic [ipfx_pkg::TABLE_ENTRIES-1:0] valid_r;
  logic [ipfx_pkg::CNT_W-1:0]         count_r;

  // Command held for the duration of the scan
  logic [ipfx_pkg::CMD_W-1:0]   cmd_r;
  logic [ipfx_pkg::ADDR_W-1:0]  key_r;
  logic [ipfx_pkg::ADDR_W-1:0]  mask_r;
  logic [ipfx_pkg::LEN_W-1:0]   len_r;
  logic                         len_ok_r;

  // Scan pipeline and accumulators
  logic [ipfx_pkg::ISSUE_W-1:0]       issue_cnt_r;
  logic                               p_vld_r;
  logic [ipfx_pkg::IDX_W-1:0]         p_idx_r;
  logic                               cov_r;
  logic                               found_r;
  logic [ipfx_pkg::IDX_W-1:0]         slot_r;
  logic [ipfx_pkg::TABLE_ENTRIES-1:0] rm_r;
  logic [ipfx_pkg::CNT_W-1:0]         rm_cnt_r;

  // Result register
  logic                          out_valid_r;
  logic                          out_hit_r;
  logic [ipfx_pkg::STATUS_W-1:0] out_status_r;
  logic [ipfx_pkg::CNT_W-1:0]    out_count_r;

  logic                         accept;
  logic                         issuing;
  logic                         finish;
  logic                         scan_last;
  logic [ipfx_pkg::ADDR_W-1:0]  in_addr;
  logic [ipfx_pkg::ADDR_W-1:0]  in_mask;
  logic                         in_len_ok;
  logic                         ram_we;
  ipfx_pkg::entry_t             ram_wdata;
  logic [ipfx_pkg::ENTRY_W-1:0] ram_rdata;
  ipfx_pkg::entry_t             rd_entry;
  ipfx_pkg::match_t             match;
  logic                         p_free;

  // Finish-step results
  logic                               res_hit;
  logic [ipfx_pkg::STATUS_W-1:0]      res_status;
  logic [ipfx_pkg::CNT_W-1:0]         res_count;
  logic [ipfx_pkg::TABLE_ENTRIES-1:0] res_valid;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_addr   = {in_addr_high, in_addr_low};
  assign in_mask   = ipfx_pkg::prefix_mask(in_prefix_len);
  assign in_len_ok = (in_prefix_len != '0) &&
                     (in_prefix_len <= ipfx_pkg::LEN_W'(ipfx_pkg::ADDR_W));

  assign issuing   = (state_r == S_SCAN) &&
                     (issue_cnt_r < ipfx_pkg::ISSUE_W'(ipfx_pkg::TABLE_ENTRIES));
  assign scan_last = p_vld_r && (p_idx_r == ipfx_pkg::IDX_W'(ipfx_pkg::TABLE_ENTRIES - 1));
  // Finish only once the result register can take the new item
  assign finish    = (state_r == S_DONE) && !(out_valid_r && out_stall);

  assign rd_entry  = ipfx_pkg::entry_t'(ram_rdata);
  // Slot counts as free once its contained prefix is dropped
  assign p_free    = !valid_r[p_idx_r] || match.contained;

  ipfx_ram #(
    .WIDTH (ipfx_pkg::ENTRY_W),
    .DEPTH (ipfx_pkg::TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .re    (issuing),
    .raddr (issue_cnt_r[ipfx_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  ipfx_match u_match (
    .entry       (rd_entry),
    .entry_valid (valid_r[p_idx_r]),
    .key         (key_r),
    .key_mask    (mask_r),
    .result      (match)
  );

  // Work out the outcome of the held command and the table after it
  always_comb begin
    res_hit    = 1'b0;
    res_status = ipfx_pkg::ST_OK;
    res_count  = count_r;
    res_valid  = valid_r;
    ram_we     = 1'b0;
    ram_wdata.net = key_r;
    ram_wdata.len = len_r;
    case (cmd_r)
      ipfx_pkg::CMD_LOOKUP: begin
        res_hit = cov_r;
      end
      ipfx_pkg::CMD_INSERT: begin
        if (!len_ok_r) begin
          res_status = ipfx_pkg::ST_BADLEN;
        end else if (cov_r) begin
          res_hit    = 1'b1;
          res_status = ipfx_pkg::ST_COVERED;
        end else begin
          // Drop contained prefixes whether or not the new one fits
          res_valid = valid_r & ~rm_r;
          res_count = count_r - rm_cnt_r;
          if (found_r) begin
            res_valid[slot_r] = 1'b1;
            res_count         = res_count + ipfx_pkg::CNT_W'(1);
            ram_we            = finish;
          end else begin
            res_status = ipfx_pkg::ST_FULL;
          end
        end
      end
      ipfx_pkg::CMD_CLEAR: begin
        res_valid = '0;
        res_count = '0;
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken, unless a finish below reloads it
      if (out_valid_r && !out_stall && !finish) begin
        out_valid_r <= 1'b0;
      end

      p_vld_r <= issuing;
      p_idx_r <= issue_cnt_r[ipfx_pkg::IDX_W-1:0];

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r       <= in_command;
            mask_r      <= in_mask;
            len_r       <= in_prefix_len;
            len_ok_r    <= in_len_ok;
            key_r       <= (in_command == ipfx_pkg::CMD_INSERT) ? (in_addr & in_mask)
                                                                : in_addr;
            issue_cnt_r <= '0;
            cov_r       <= 1'b0;
            found_r     <= 1'b0;
            slot_r      <= '0;
            rm_r        <= '0;
            rm_cnt_r    <= '0;
            if ((in_command == ipfx_pkg::CMD_LOOKUP) ||
                ((in_command == ipfx_pkg::CMD_INSERT) && in_len_ok)) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (issuing) begin
            issue_cnt_r <= issue_cnt_r + ipfx_pkg::ISSUE_W'(1);
          end
          if (p_vld_r) begin
            // Fold one entry into the accumulators
            cov_r          <= cov_r || match.covers;
            rm_r[p_idx_r]  <= match.contained;
            rm_cnt_r       <= rm_cnt_r + ipfx_pkg::CNT_W'(match.contained);
            if (!found_r && p_free) begin
              found_r <= 1'b1;
              slot_r  <= p_idx_r;
            end
          end
          if (scan_last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (finish) begin
            valid_r      <= res_valid;
            count_r      <= res_count;
            out_valid_r  <= 1'b1;
            out_hit_r    <= res_hit;
            out_status_r <= res_status;
            out_count_r  <= res_count;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  // Count never exceeds the table size
  `IPFX_ASSERT(a_count_bound, clk, rst_n, count_r <= ipfx_pkg::CNT_W'(ipfx_pkg::TABLE_ENTRIES), "entry count above table size")
  // Between commands the count matches the number of valid entries
  `IPFX_ASSERT_IMPL(a_count_matches, clk, rst_n, state_r == S_IDLE, $countones(valid_r) == int'(count_r), "entry count out of step with valid bits")
  // A finish always presents a result in the next cycle
  `IPFX_ASSERT_NEXT(a_finish_shows, clk, rst_n, finish, out_valid_r, "finished command gave no result")

endmodule

>>> bench/ipv6_prefix_membership_table_top_tb.sv
// Self-checking bench for the IPv6 prefix membership table: directed and random commands
// against an in-bench model of the prefix set, with each result checked in order.
// Depends on ipfx_pkg and ipv6_prefix_membership_table_top.
module ipv6_prefix_membership_table_top_tb;
  localparam int TABLE_ENTRIES = ipfx_pkg::TABLE_ENTRIES;
  localparam int ADDR_W        = ipfx_pkg::ADDR_W;
  localparam int HALF_W        = ipfx_pkg::HALF_W;
  localparam int LEN_W         = ipfx_pkg::LEN_W;
  localparam int CNT_W         = ipfx_pkg::CNT_W;
  localparam int CMD_W         = ipfx_pkg::CMD_W;
  localparam int STATUS_W      = ipfx_pkg::STATUS_W;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = ipfx_pkg::CMD_LOOKUP;
  localparam logic [CMD_W-1:0] CMD_INSERT = ipfx_pkg::CMD_INSERT;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = ipfx_pkg::CMD_CLEAR;

  localparam logic [STATUS_W-1:0] ST_COVERED = ipfx_pkg::ST_COVERED;
  localparam logic [STATUS_W-1:0] ST_BADLEN  = ipfx_pkg::ST_BADLEN;
  localparam logic [STATUS_W-1:0] ST_FULL    = ipfx_pkg::ST_FULL;

  // Command code 3 is unused by the block. It must change nothing.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int RUN_LIMIT    = 1_000_000;
  // A full table scan fits in SETTLE, with room left for the settle time at the end.
  localparam int SETTLE       = TABLE_ENTRIES + 16;
  localparam int RANDOM_ITEMS = 1650;
  localparam int SEEDS        = 16;

  typedef struct packed {
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
  } answer_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command;
  logic [HALF_W-1:0]   in_addr_high;
  logic [HALF_W-1:0]   in_addr_low;
  logic [LEN_W-1:0]    in_prefix_len;
  logic                out_valid;
  logic                out_stall;
  logic                out_hit;
  logic [STATUS_W-1:0] out_status;
  logic [CNT_W-1:0]    out_entry_count;

  // Bench copy of the prefix set.
  logic                set_valid [TABLE_ENTRIES];
  logic [ADDR_W-1:0]   set_net   [TABLE_ENTRIES];
  logic [LEN_W-1:0]    set_len   [TABLE_ENTRIES];
  int                  set_count = 0;

  answer_t             answers_due[$];
  answer_t             due_answer;
  logic [ADDR_W-1:0]   seeds [SEEDS];
  int                  errors      = 0;
  int                  cycle_count = 0;
  int                  tx_calm     = 0;
  int                  rx_calm     = 0;
  int                  rx_hold     = 0;

  ipv6_prefix_membership_table_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_addr_high    (in_addr_high),
    .in_addr_low     (in_addr_low),
    .in_prefix_len   (in_prefix_len),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Network order: the top len bits of the 128-bit value form the network part.
  function automatic logic [ADDR_W-1:0] len_mask(input int len);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    return (len <= 0) ? '0 : ones << (ADDR_W - len);
  endfunction

  function automatic bit set_covers(input logic [ADDR_W-1:0] addr);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (set_valid[i] && ((addr & len_mask(int'(set_len[i]))) == set_net[i]))
        return 1'b1;
    return 1'b0;
  endfunction

  // Apply one command to the bench copy of the set. Return the answer that the block
  // should give for it.
  function automatic answer_t apply_command(input logic [CMD_W-1:0] cmd,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [LEN_W-1:0] len);
    answer_t           ans;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] net;
    int                slot;
    ans  = '0;
    slot = -1;
    case (cmd)
      CMD_LOOKUP: ans.hit = set_covers(addr);
      CMD_INSERT: begin
        if (len == 0 || len > ADDR_W) begin
          ans.status = ST_BADLEN;
        end else begin
          mask = len_mask(int'(len));
          net  = addr & mask;
          if (set_covers(net)) begin
            ans.hit    = 1'b1;
            ans.status = ST_COVERED;
          end else begin
            // Drop every stored prefix that lies inside the new one before
            // looking for the lowest free slot.
            for (int i = 0; i < TABLE_ENTRIES; i++)
              if (set_valid[i] && ((set_net[i] & mask) == net)) begin
                set_valid[i] = 1'b0;
                set_count--;
              end
            for (int i = 0; i < TABLE_ENTRIES; i++)
              if (!set_valid[i] && slot < 0)
                slot = i;
            if (slot < 0) begin
              ans.status = ST_FULL;
            end else begin
              set_valid[slot] = 1'b1;
              set_net[slot]   = net;
              set_len[slot]   = len;
              set_count++;
            end
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          set_valid[i] = 1'b0;
        set_count = 0;
      end
      default: ;
    endcase
    ans.count = set_count[CNT_W-1:0];
    return ans;
  endfunction

  // Idle cycles before the next item is sent or taken. A zero gap stretch is
  // started now and then, so that items also follow one another back to back.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0)
      calm_left = $urandom_range(8, 40);
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Return an address that shares a random number of leading bits with a seed.
  // Random inserts and lookups then cover, contain and hit one another.
  function automatic logic [ADDR_W-1:0] near_seed();
    return seeds[$urandom_range(0, SEEDS - 1)] ^
           (rand_addr() & ~len_mask(int'($urandom_range(16, ADDR_W))));
  endfunction

  task automatic refresh_seeds();
    for (int i = 0; i < SEEDS; i++)
      seeds[i] = rand_addr();
  endtask

  // Drive one item. Valid stays high from the previous item when there is no gap.
  // Hold the item until it is taken, then record the answer that is due for it.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                           input logic [LEN_W-1:0] len);
    int gap;
    gap = draw_wait(tx_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_addr_high  <= addr[ADDR_W-1:HALF_W];
    in_addr_low   <= addr[HALF_W-1:0];
    in_prefix_len <= len;
    do @(posedge clk); while (in_stall);
    answers_due.push_back(apply_command(cmd, addr, len));
  endtask

  // Drop valid, wait for every result that is still due, then let a full scan
  // pass so that any stray result still shows up.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Check each result when it is taken, against the oldest answer that is due.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        $display("%0t: result expected none got hit %0b status %0d count %0d",
                 $time, out_hit, out_status, out_entry_count);
        errors++;
      end else begin
        due_answer = answers_due.pop_front();
        check_field("hit", 8'(due_answer.hit), 8'(out_hit));
        check_field("status", 8'(due_answer.status), 8'(out_status));
        check_field("entry_count", 8'(due_answer.count), 8'(out_entry_count));
      end
      rx_hold = draw_wait(rx_calm);
    end
  end

  // Spend the stall drawn for each result mostly while that result waits. Stall
  // now and then on an empty output too.
  always @(negedge clk) begin
    if (rx_hold > 0 && (out_valid || $urandom_range(0, 3) == 0)) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("FAIL ipv6_prefix_membership_table_top");
      $finish;
    end
  end

  task automatic test_empty_table();
    send_item(CMD_LOOKUP, '0, 8'd0);
    send_item(CMD_LOOKUP, '1, 8'hFF);
    send_item(CMD_SPARE, '1, 8'd64);
    send_item(CMD_CLEAR, '0, 8'd0);
  endtask

  task automatic test_bad_length();
    send_item(CMD_INSERT, '1, 8'd0);
    send_item(CMD_INSERT, '1, 8'd129);
    send_item(CMD_INSERT, '0, 8'd255);
    send_item(CMD_LOOKUP, '1, 8'd0);
  endtask

  task automatic test_length_extremes();
    send_item(CMD_INSERT, '1, 8'd128);
    send_item(CMD_LOOKUP, '1, 8'd0);
    send_item(CMD_LOOKUP, {{(ADDR_W-1){1'b1}}, 1'b0}, 8'd0);
    send_item(CMD_INSERT, '0, 8'd1);
    send_item(CMD_LOOKUP, {1'b0, {(ADDR_W-1){1'b1}}}, 8'd0);
    // Replace the /128 entry with the upper half of the address space.
    send_item(CMD_INSERT, '1, 8'd1);
    send_item(CMD_INSERT, '0, 8'd128);
  endtask

  task automatic test_cover_and_contain();
    send_item(CMD_CLEAR, '1, 8'd0);
    send_item(CMD_INSERT, 128'h2001_0db8_0001_0000_0000_0000_0000_0000, 8'd48);
    send_item(CMD_INSERT, 128'h2001_0db8_0001_0002_0000_0000_0000_0000, 8'd64);
    send_item(CMD_INSERT, 128'h2001_0db8_ff00_0000_0000_0000_0000_0000, 8'd40);
    // The /32 swallows both entries stored above; the /64 was covered by the /48.
    send_item(CMD_INSERT, 128'h2001_0db8_0000_0000_0000_0000_0000_0000, 8'd32);
    send_item(CMD_INSERT, 128'h2001_0db8_abcd_0000_0000_0000_0000_0001, 8'd32);
    send_item(CMD_LOOKUP, 128'h2001_0db8_ffff_0000_0000_0000_0000_0001, 8'd0);
    send_item(CMD_LOOKUP, 128'h2001_0db9_0000_0000_0000_0000_0000_0000, 8'd0);
    send_item(CMD_INSERT, 128'h2001_0db9_0000_0000_c000_0000_0000_0000, 8'd65);
  endtask

  // Fill every slot with unrelated long prefixes and push past capacity. Then insert a
  // short prefix that frees room by absorbing whatever lies under it.
  task automatic test_fill_to_capacity();
    logic [ADDR_W-1:0] first;
    send_item(CMD_CLEAR, '0, 8'd0);
    first = rand_addr();
    send_item(CMD_INSERT, first, 8'd128);
    for (int i = 0; i < TABLE_ENTRIES + 3; i++)
      send_item(CMD_INSERT, rand_addr(), LEN_W'($urandom_range(96, 128)));
    send_item(CMD_INSERT, first, 8'd128);
    send_item(CMD_INSERT, first, 8'd4);
    send_item(CMD_INSERT, rand_addr(), 8'd128);
    send_item(CMD_LOOKUP, first, 8'd0);
  endtask

  // Mostly well-formed lookups and inserts around a handful of seed networks,
  // with bad lengths, unused commands and the odd clear mixed in.
  task automatic test_random_commands();
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    int                pick;
    refresh_seeds();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 199);
      addr = near_seed();
      if (pick < 80) begin
        if ($urandom_range(0, 4) == 0)
          addr = rand_addr();
        send_item(CMD_LOOKUP, addr, LEN_W'($urandom_range(0, 255)));
      end else if (pick < 196) begin
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(129, 255));
          1, 2:    len = LEN_W'($urandom_range(1, 23));
          default: len = LEN_W'($urandom_range(24, 128));
        endcase
        send_item(CMD_INSERT, addr, len);
      end else if (pick < 199) begin
        send_item(CMD_SPARE, rand_addr(), LEN_W'($urandom_range(0, 255)));
      end else begin
        send_item(CMD_CLEAR, rand_addr(), LEN_W'($urandom_range(0, 255)));
        refresh_seeds();
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_LOOKUP;
    in_addr_high  = '0;
    in_addr_low   = '0;
    in_prefix_len = '0;
    out_stall     = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      set_valid[i] = 1'b0;
      set_net[i]   = '0;
      set_len[i]   = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_bad_length();
    test_length_extremes();
    test_cover_and_contain();
    test_fill_to_capacity();
    test_random_commands();
    drain();

    if (errors == 0)
      $display("PASS ipv6_prefix_membership_table_top");
    else
      $display("FAIL ipv6_prefix_membership_table_top");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/ipfx_pkg.sv
sv/ipfx_ram.sv
sv/ipfx_match.sv
sv/ipv6_prefix_membership_table_top.sv
bench/ipv6_prefix_membership_table_top_tb.sv
